>>> rtl/core/ppmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared constants, word types and register codes for the sum-PPM decoder
// with channel-switch demultiplexer.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  // Frame geometry
  localparam int NUM_CHANNELS = 7;
  localparam int FUNC_ENTRIES = 2 * NUM_CHANNELS;
  localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
  localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);
  localparam int FIDX_W       = $clog2(FUNC_ENTRIES);

  // Fixed field widths
  localparam int ACTION_W = 1;
  localparam int WIDTH_W  = 16;
  localparam int TRIM_W   = 4;
  localparam int SW_W     = 3;
  localparam int LEVEL_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CH_IDX_W-1:0] chan_idx_t;
  typedef logic [CNT_W-1:0]    chan_cnt_t;
  typedef logic [FIDX_W-1:0]   func_idx_t;
  typedef logic [LEVEL_W-1:0]  level_t;

  localparam chan_cnt_t CH_COUNT    = CNT_W'(NUM_CHANNELS);
  localparam level_t    RESET_LEVEL = 8'd188;
  localparam level_t    LEVEL_MAX   = 8'd255;

  // Word actions
  localparam logic ACT_CAPTURE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIM       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_CH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIM  = 3'd4;

  // Register reset values
  localparam logic [TRIM_W-1:0]  TRIM_RST      = 4'd3;
  localparam logic [WIDTH_W-1:0] SYNC_THR_RST  = 16'd275;
  localparam logic [SW_W-1:0]    SWITCH_CH_RST = 3'd4;
  localparam level_t             UPPER_LIM_RST = 8'd245;
  localparam level_t             LOWER_LIM_RST = 8'd130;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WIDTH_W-1:0]  pulse_width;
  } in_word_t;

  typedef struct packed {
    logic       sync_seen;
    logic       channel_stored;
    logic [2:0] channel_index;
    logic [7:0] channel_value;
    logic       func_written;
    logic [3:0] func_index;
    logic [7:0] func_value;
  } out_word_t;

  typedef struct packed {
    logic [TRIM_W-1:0]  trim;
    logic [WIDTH_W-1:0] sync_threshold;
    logic [SW_W-1:0]    switch_channel;
    level_t             upper_limit;
    level_t             lower_limit;
  } cfg_t;

  // Channel store write request
  typedef struct packed {
    logic      en;
    chan_idx_t addr;
    level_t    data;
  } store_wr_t;

endpackage

>>> rtl/core/ppm_decoder_channel_switch_demux_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_decoder_channel_switch_demux_unit
// Sum-PPM decoder with channel-switch demultiplexer, top level.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_ready is high: a captured pulse width or a
// demultiplex tick. Each word gives exactly one result word: the accepting
// edge loads the input register, and the decode result is loaded into the
// result register once that register is free. The rate of one word per
// cycle, while the receiver keeps up, is set by the single decode stage,
// whose channel store reads are prefetched so a tick sees a capture made the
// cycle before. The function entries are not kept here: every copy into the
// function store is reported in the result word (func_written, func_index,
// func_value) for the downstream holder. No clearing pass follows reset.
// Write configuration only while no word is in flight.
module ppm_decoder_channel_switch_demux_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ppmd_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ppmd_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ppmd_pkg::*;

  cfg_t      cfg;
  cfg_t      cfg_next;
  logic      s1_valid;
  in_word_t  s1_word;
  logic      advance;
  logic      fire;
  store_wr_t wr;
  chan_cnt_t copy_index_next;
  level_t    switch_level;
  level_t    copy_level;
  out_word_t result;

  // Handshake
  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  ppmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cfg_next  (cfg_next)
  );

  ppmd_chan_store u_store (
    .clk              (clk),
    .rst              (rst),
    .wr               (wr),
    .switch_addr_next (cfg_next.switch_channel),
    .copy_addr_next   (copy_index_next),
    .switch_level     (switch_level),
    .copy_level       (copy_level)
  );

  ppmd_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .word            (s1_word),
    .cfg             (cfg),
    .switch_level    (switch_level),
    .copy_level      (copy_level),
    .wr              (wr),
    .copy_index_next (copy_index_next),
    .result          (result)
  );

  // Input register: load on accept, drop once decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_data;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // A decoded word always lands in the result register
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("decoded word did not reach result register");

  // A stall at the input only comes from a full pipeline
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled with room in pipeline");

  // A result reports at most one kind of action
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({out_data.sync_seen, out_data.channel_stored,
                               out_data.func_written}) <= 1))
    else $error("result reports more than one action");

  // Function writes stay inside the function store
  a_func_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.func_written) |-> (32'(out_data.func_index) < FUNC_ENTRIES))
    else $error("function index out of range");
`endif

endmodule

>>> rtl/core/ppmd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_cfg_regs
// Configuration registers; also presents the value they take at the next edge.
// ----------------------------------------------------------------------------
module ppmd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ppmd_pkg::cfg_t                cfg,
  output ppmd_pkg::cfg_t                cfg_next
);
  import ppmd_pkg::*;

  // Decode the write into the next register image
  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      case (cfg_index)
        REG_TRIM:      cfg_next.trim           = cfg_wdata[TRIM_W-1:0];
        REG_SYNC_THR:  cfg_next.sync_threshold = cfg_wdata[WIDTH_W-1:0];
        REG_SWITCH_CH: cfg_next.switch_channel = cfg_wdata[SW_W-1:0];
        REG_UPPER_LIM: cfg_next.upper_limit    = cfg_wdata[LEVEL_W-1:0];
        REG_LOWER_LIM: cfg_next.lower_limit    = cfg_wdata[LEVEL_W-1:0];
        default:       cfg_next = cfg;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trim           <= TRIM_RST;
      cfg.sync_threshold <= SYNC_THR_RST;
      cfg.switch_channel <= SWITCH_CH_RST;
      cfg.upper_limit    <= UPPER_LIM_RST;
      cfg.lower_limit    <= LOWER_LIM_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

>>> rtl/core/ppmd_chan_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_chan_store
// Channel slot store with two registered read ports. The read addresses are
// the next-cycle switch channel and copy index, and a write in the same cycle
// is forwarded, so the read registers always mirror the current store.
// ----------------------------------------------------------------------------
module ppmd_chan_store (
  input  logic                    clk,
  input  logic                    rst,
  input  ppmd_pkg::store_wr_t     wr,
  input  logic [ppmd_pkg::SW_W-1:0] switch_addr_next,
  input  ppmd_pkg::chan_cnt_t     copy_addr_next,
  output ppmd_pkg::level_t        switch_level,
  output ppmd_pkg::level_t        copy_level
);
  import ppmd_pkg::*;

  level_t    store [NUM_CHANNELS];
  level_t    store_next [NUM_CHANNELS];
  chan_idx_t sw_idx;
  chan_idx_t cp_idx;
  logic      sw_in_range;
  logic      cp_in_range;
  level_t    switch_level_next;
  level_t    copy_level_next;

  // Apply the pending write
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      store_next[i] = store[i];
    end
    if (wr.en) begin
      store_next[wr.addr] = wr.data;
    end
  end

  // Look up both read addresses against the updated store
  always_comb begin
    sw_in_range = (32'(switch_addr_next) < NUM_CHANNELS);
    cp_in_range = (copy_addr_next < CH_COUNT);
    sw_idx      = sw_in_range ? CH_IDX_W'(switch_addr_next) : '0;
    cp_idx      = cp_in_range ? CH_IDX_W'(copy_addr_next) : '0;
    switch_level_next = store_next[sw_idx];
    copy_level_next   = store_next[cp_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store[i] <= RESET_LEVEL;
      end
      switch_level <= RESET_LEVEL;
      copy_level   <= RESET_LEVEL;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store[i] <= store_next[i];
      end
      switch_level <= switch_level_next;
      copy_level   <= copy_level_next;
    end
  end

endmodule

>>> rtl/core/ppmd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_decode
// Per-word decode: sync detection and channel capture for pulse widths,
// switch-selected copy for ticks. Holds the capture and copy indexes.
// ----------------------------------------------------------------------------
module ppmd_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  ppmd_pkg::in_word_t   word,
  input  ppmd_pkg::cfg_t       cfg,
  input  ppmd_pkg::level_t     switch_level,
  input  ppmd_pkg::level_t     copy_level,
  output ppmd_pkg::store_wr_t  wr,
  output ppmd_pkg::chan_cnt_t  copy_index_next,
  output ppmd_pkg::out_word_t  result
);
  import ppmd_pkg::*;

  chan_cnt_t             capture_index;
  chan_cnt_t             capture_index_next;
  chan_cnt_t             copy_index;
  logic [WIDTH_W:0]      trimmed;
  level_t                level;
  logic                  sw_ok;
  logic                  low_half;
  logic                  high_half;
  logic [CNT_W:0]        dst;

  // Trim and saturate the width
  always_comb begin
    trimmed = {1'b0, word.pulse_width} + (WIDTH_W + 1)'(cfg.trim);
    level   = (trimmed > (WIDTH_W + 1)'(LEVEL_MAX)) ? LEVEL_MAX : trimmed[LEVEL_W-1:0];
  end

  // Classify the switch channel value
  always_comb begin
    sw_ok     = (32'(cfg.switch_channel) < NUM_CHANNELS);
    low_half  = switch_level > cfg.upper_limit;
    high_half = switch_level < cfg.lower_limit;
    dst       = low_half ? {1'b0, copy_index}
                         : {1'b0, copy_index} + (CNT_W + 1)'(NUM_CHANNELS);
  end

  // Decode one word
  always_comb begin
    result             = '0;
    wr                 = '0;
    capture_index_next = capture_index;
    copy_index_next    = copy_index;
    if (fire) begin
      if (word.action == ACT_CAPTURE) begin
        if (word.pulse_width > cfg.sync_threshold) begin
          capture_index_next = '0;
          result.sync_seen   = 1'b1;
        end else if (capture_index < CH_COUNT) begin
          wr.en                = 1'b1;
          wr.addr              = CH_IDX_W'(capture_index);
          wr.data              = level;
          result.channel_stored = 1'b1;
          result.channel_index  = 3'(capture_index);
          result.channel_value  = level;
          capture_index_next    = capture_index + 1'b1;
        end
      end else if (sw_ok && (low_half || high_half)) begin
        if (copy_index < CH_COUNT) begin
          result.func_written = 1'b1;
          result.func_index   = 4'(dst);
          result.func_value   = copy_level;
          copy_index_next     = copy_index + 1'b1;
        end else begin
          copy_index_next = '0;
        end
      end
    end
  end

  // Advance the indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_index <= '0;
      copy_index    <= '0;
    end else begin
      capture_index <= capture_index_next;
      copy_index    <= copy_index_next;
    end
  end

endmodule

>>> verif/ppmd_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_decode_checker
// Watches the word channels and register writes of the sum-PPM decoder, keeps
// its own decode of every accepted input word and compares each result word
// with the oldest decoded word still owed.
// ----------------------------------------------------------------------------
module ppmd_decode_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ppmd_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ppmd_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              words_checked,
  output int                              words_owed
);
  import ppmd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Mirror of the registers and the decoder state
  cfg_t      regs;
  level_t    chan_level [NUM_CHANNELS];
  chan_cnt_t capture_pos;
  chan_cnt_t copy_pos;
  out_word_t decoded_words [$];

  function automatic string show_word(out_word_t w);
    return $sformatf("sync=%0d ch(stored=%0d idx=%0d val=%0d) fn(written=%0d idx=%0d val=%0d)",
                     w.sync_seen, w.channel_stored, w.channel_index, w.channel_value,
                     w.func_written, w.func_index, w.func_value);
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Decode one word: update the channel slots and capture and copy indexes, build the result
  function automatic out_word_t decode_word(in_word_t w);
    out_word_t        r;
    logic [WIDTH_W:0] sum;
    level_t           sel;
    logic             to_low;
    logic             to_high;
    r = '0;
    if (w.action == ACT_CAPTURE) begin
      if (w.pulse_width > regs.sync_threshold) begin
        capture_pos = '0;
        r.sync_seen = 1'b1;
      end else if (capture_pos < CH_COUNT) begin
        // trim and saturate at the top level
        sum = w.pulse_width + regs.trim;
        chan_level[capture_pos] = (sum > LEVEL_MAX) ? LEVEL_MAX : sum[LEVEL_W-1:0];
        r.channel_stored = 1'b1;
        r.channel_index  = capture_pos;
        r.channel_value  = chan_level[capture_pos];
        capture_pos      = capture_pos + 1'b1;
      end
      // past the last slot before a sync: drop the capture
    end else if (regs.switch_channel < NUM_CHANNELS) begin
      sel     = chan_level[regs.switch_channel];
      to_low  = sel > regs.upper_limit;
      to_high = sel < regs.lower_limit;
      if (to_low || to_high) begin
        if (copy_pos < CH_COUNT) begin
          // upper limit wins when both halves qualify
          r.func_written = 1'b1;
          r.func_index   = to_low ? func_idx_t'(copy_pos)
                                  : func_idx_t'(copy_pos) + func_idx_t'(NUM_CHANNELS);
          r.func_value   = chan_level[copy_pos];
          copy_pos       = copy_pos + 1'b1;
        end else begin
          copy_pos = '0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      regs.trim           = TRIM_RST;
      regs.sync_threshold = SYNC_THR_RST;
      regs.switch_channel = SWITCH_CH_RST;
      regs.upper_limit    = UPPER_LIM_RST;
      regs.lower_limit    = LOWER_LIM_RST;
      foreach (chan_level[i]) chan_level[i] = RESET_LEVEL;
      capture_pos = '0;
      copy_pos    = '0;
      decoded_words.delete();
      fail_count    = 0;
      words_checked = 0;
    end else begin
      // Compare the result word before taking a new input word
      if (out_valid && out_ready) begin
        if (decoded_words.size() == 0) begin
          note_failure({"result word with nothing owed: ", show_word(out_data)});
        end else begin
          want = decoded_words.pop_front();
          words_checked++;
          if (out_data.sync_seen      !== want.sync_seen      ||
              out_data.channel_stored !== want.channel_stored ||
              out_data.channel_index  !== want.channel_index  ||
              out_data.channel_value  !== want.channel_value  ||
              out_data.func_written   !== want.func_written   ||
              out_data.func_index     !== want.func_index     ||
              out_data.func_value     !== want.func_value) begin
            note_failure({"result word differs\n  expected ", show_word(want),
                          "\n  actual   ", show_word(out_data)});
          end
        end
      end
      if (in_valid && in_ready) begin
        decoded_words.push_back(decode_word(in_data));
      end
      // Track register writes; unknown indexes do nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIM:      regs.trim           = cfg_wdata[TRIM_W-1:0];
          REG_SYNC_THR:  regs.sync_threshold = cfg_wdata[WIDTH_W-1:0];
          REG_SWITCH_CH: regs.switch_channel = cfg_wdata[SW_W-1:0];
          REG_UPPER_LIM: regs.upper_limit    = cfg_wdata[LEVEL_W-1:0];
          REG_LOWER_LIM: regs.lower_limit    = cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    words_owed = decoded_words.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sum-PPM decoder with channel-switch demux.
// A directed run on reset settings is followed by blocks of framed random
// traffic under a series of register settings, with sender and receiver
// idling in turn and one long receiver hold-off; a checker module beside the
// block decodes every word on its own and compares the result words.
// ----------------------------------------------------------------------------
module tb;
  import ppmd_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_PAD   = 4;
  localparam int HOLD_CYCLES = 120;
  localparam int BLOCK_WORDS = 135;
  localparam int NUM_BLOCKS  = 12;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int words_checked;
  int words_owed;

  int                 send_idle_pct = 18;
  int                 recv_idle_pct = 76;
  bit                 hold_req      = 1'b0;
  int                 hold_left     = 0;
  int                 quiet_cycles  = 0;
  int                 n_captures    = 0;
  int                 n_ticks       = 0;
  int                 n_settings    = 0;
  logic [WIDTH_W-1:0] cur_thr       = SYNC_THR_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ppm_decoder_channel_switch_demux_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ppmd_decode_checker decode_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_checked (words_checked),
    .words_owed    (words_owed)
  );

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results owed",
               quiet_cycles, words_owed);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one word, idling first at the sender's rate; hold until accepted
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [WIDTH_W-1:0] width);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data.action      <= act;
    in_data.pulse_width <= width;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_CAPTURE) n_captures++;
    else n_ticks++;
  endtask

  task automatic capture(input logic [WIDTH_W-1:0] width);
    send_word(ACT_CAPTURE, width);
  endtask

  // Tick payload is ignored by the block; keep it random
  task automatic tick();
    send_word(ACT_TICK, WIDTH_W'($urandom));
  endtask

  // Write one register with random bits above its width
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                         input int nbits);
    logic [CFG_DATA_W-1:0] keep;
    keep = (nbits >= CFG_DATA_W) ? '1 : CFG_DATA_W'((1 << nbits) - 1);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (CFG_DATA_W'($urandom) & ~keep) | (val & keep);
  endtask

  task automatic write_settings(input logic [TRIM_W-1:0] t, input logic [WIDTH_W-1:0] thr,
                                input logic [SW_W-1:0] sw, input level_t up, input level_t lo);
    put_reg(REG_TRIM, CFG_DATA_W'(t), TRIM_W);
    put_reg(REG_SYNC_THR, CFG_DATA_W'(thr), WIDTH_W);
    put_reg(REG_SWITCH_CH, CFG_DATA_W'(sw), SW_W);
    put_reg(REG_UPPER_LIM, CFG_DATA_W'(up), LEVEL_W);
    put_reg(REG_LOWER_LIM, CFG_DATA_W'(lo), LEVEL_W);
    // unknown index last, so an aliased decode would clobber a live register
    put_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
            CFG_DATA_W'($urandom), CFG_DATA_W);
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_thr = thr;
    n_settings++;
  endtask

  // Drop valid, wait until every result is in, then let the pipe settle
  task automatic drain_all();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  // Channel widths cluster near the limits and the saturation point
  function automatic logic [WIDTH_W-1:0] chan_width();
    case ($urandom_range(4))
      0:       return WIDTH_W'($urandom_range(15));
      1:       return WIDTH_W'($urandom_range(140, 110));
      2:       return WIDTH_W'($urandom_range(260, 230));
      3:       return WIDTH_W'($urandom_range(255));
      default: return WIDTH_W'($urandom);
    endcase
  endfunction

  function automatic logic [WIDTH_W-1:0] sync_width();
    if (cur_thr == '1) return WIDTH_W'($urandom);
    return WIDTH_W'($urandom_range(65535, int'(cur_thr) + 1));
  endfunction

  // Mostly framed traffic (sync, a channel run, some ticks), the rest noise
  task automatic run_block(input int n_words);
    int stop_at;
    int n_ch;
    stop_at = n_captures + n_ticks + n_words;
    while (n_captures + n_ticks < stop_at) begin
      if ($urandom_range(9) < 7) begin
        capture(sync_width());
        n_ch = ($urandom_range(3) == 0) ? $urandom_range(10) : NUM_CHANNELS;
        repeat (n_ch) capture(chan_width());
        repeat ($urandom_range(9, 1)) tick();
      end else begin
        send_word(ACTION_W'($urandom_range(1)), WIDTH_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed run on reset settings
    tick();              // switch slot at reset level sits between the limits
    capture(16'd0);
    capture(16'd276);    // just above the sync threshold
    capture(16'd275);    // at the threshold, saturates with trim
    capture(16'd7);
    capture(16'd97);
    capture(16'd127);    // lands exactly on the lower limit
    capture(16'd250);    // switch slot above the upper limit
    capture(16'd242);
    capture(16'd126);
    capture(16'd1);      // eighth channel in the frame, dropped
    repeat (NUM_CHANNELS) tick();
    tick();              // copy index wraps without a copy
    tick();
    capture(16'hFFFF);
    capture(16'd255);

    for (int b = 0; b < NUM_BLOCKS; b++) begin
      drain_all();
      // three idle phases: sender light, receiver light, none
      if (b < NUM_BLOCKS / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 76;
      end else if (b < 2 * NUM_BLOCKS / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (b == 2 * NUM_BLOCKS / 3) hold_req = 1'b1;
      case (b)
        0: write_settings(TRIM_RST, SYNC_THR_RST, SWITCH_CH_RST, UPPER_LIM_RST, LOWER_LIM_RST);
        1: write_settings(4'd15, 16'hFFFF, 3'd0, 8'd255, 8'd0);
        // zero threshold: only zero widths store; overlapping limits
        2: write_settings(4'd0, 16'd0, 3'd6, 8'd0, 8'd255);
        // switch channel past the last slot
        3: write_settings(4'd7, 16'd275, 3'd7, 8'd245, 8'd130);
        4: write_settings(4'd5, 16'd260, 3'd2, 8'd100, 8'd200);
        5: write_settings(4'd15, 16'd300, 3'd3, 8'd250, 8'd20);
        default: write_settings(TRIM_W'($urandom_range(15)), WIDTH_W'($urandom_range(420, 180)),
                                SW_W'($urandom_range(7)), LEVEL_W'($urandom_range(255)),
                                LEVEL_W'($urandom_range(255)));
      endcase
      run_block(BLOCK_WORDS);
    end
    drain_all();

    $display("Covered %0d captures and %0d ticks under %0d register settings; %0d results checked.",
             n_captures, n_ticks, n_settings, words_checked);
    $display("Idle mix sender/receiver 18/76, 76/18, none; one %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && words_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
